/* design/cwdc_pkg.sv */
package cwdc_pkg;

	localparam logic [11:0] YEAR_BASE    = 12'd2018;
	localparam logic [11:0] YEAR_RESET   = 12'd2018;
	localparam logic [5:0]  MAX_DAY      = 6'd31;
	localparam logic [5:0]  MAX_WEEK     = 6'd53;
	localparam logic [2:0]  MAX_WEEKDAY  = 3'd6;
	localparam logic [2:0]  SUNDAY       = 3'd6;
	localparam logic [8:0]  LEAP_DAY_DOY = 9'd60;
	localparam logic [8:0]  YEAR_DAYS    = 9'd365;
	localparam logic [3:0]  FEBRUARY     = 4'd2;
	localparam logic [4:0]  LEAP_DAY_DOM = 5'd29;
	localparam logic [8:0]  RECIP_SEVEN  = 9'd73;   // 73 / 512 just under 1/7

	typedef enum logic {
		CMD_DATE_TO_WEEK = 1'b0,
		CMD_WEEK_TO_DATE = 1'b1
	} cmd_t;

	// per-year facts, held next to the year register
	typedef struct packed {
		logic       bad;    // year below the base year
		logic       leap;
		logic [2:0] jan1;   // weekday of january 1, 0 = monday
	} year_info_t;

	// days in the months before month index m (0 = january)
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// remainder by seven through octal digit folding, 8 = 1 mod 7
	function automatic logic [2:0] mod7(input logic [12:0] x);
		logic [14:0] w;
		logic [5:0]  s1;
		logic [3:0]  s2;
		w  = {2'b00, x};
		s1 = 6'(w[2:0]) + 6'(w[5:3]) + 6'(w[8:6]) + 6'(w[11:9]) + 6'(w[14:12]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		if (s2 >= 4'd7)
			s2 = s2 - 4'd7;
		return s2[2:0];
	endfunction

endpackage

/* design/cwdc_year.sv */
module cwdc_year
	import cwdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] calendar_year,
	output year_info_t  info
);

	year_info_t  info_q;
	year_info_t  info_d;
	logic [11:0] span;
	logic [12:0] leaps;
	logic [12:0] total;

	assign cfg_ready = 1'b1;

	// derive from the incoming word so the facts land with the register
	always_comb begin
		span        = calendar_year - YEAR_BASE;
		info_d.bad  = calendar_year < YEAR_BASE;
		info_d.leap = calendar_year[1:0] == 2'b00;
		leaps       = (13'(span) + 13'd2) >> 2;
		if (info_d.leap)
			leaps = leaps - 13'd1;
		total       = 13'(span) + leaps;
		info_d.jan1 = mod7(total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_q <= '{bad: 1'b0, leap: 1'b0, jan1: 3'd0};
		end else if (cfg_valid && cfg_ready) begin
			info_q <= info_d;
		end
	end

	// the year itself is only needed through its derived facts
	assign info = info_q;

endmodule

/* design/cwdc_fwd.sv */
module cwdc_fwd
	import cwdc_pkg::*;
(
	input  logic [3:0] month,
	input  logic [5:0] day_of_month,
	input  year_info_t info,
	output logic [5:0] week_number,
	output logic [2:0] weekday,
	output logic [8:0] day_of_year,
	output logic       error
);

	logic [8:0]  doy;
	logic [8:0]  t;
	logic [8:0]  x;
	logic [15:0] prod;
	logic [6:0]  q;
	logic [8:0]  r;

	always_comb begin
		error = !(month inside {[4'd1:4'd12]}) || (day_of_month > MAX_DAY);
		doy   = days_before(month - 4'd1) + 9'(day_of_month);
		if (info.leap && month > FEBRUARY)
			doy = doy + 9'd1;
		t     = doy + 9'(info.jan1);
		x     = t - 9'd1;
		// divide by seven: reciprocal estimate, then one correction
		prod  = 16'(x) * 16'(RECIP_SEVEN);
		q     = prod[15:9];
		r     = x - 9'(q) * 9'd7;
		if (r >= 9'd7) begin
			q = q + 7'd1;
			r = r - 9'd7;
		end
		if (t == 9'd0) begin
			week_number = 6'd0;
			weekday     = SUNDAY;
		end else begin
			week_number = q[5:0];
			weekday     = r[2:0];
		end
		day_of_year = doy;
	end

endmodule

/* design/cwdc_inv.sv */
module cwdc_inv
	import cwdc_pkg::*;
(
	input  logic [5:0] week_in,
	input  logic [2:0] weekday_in,
	input  year_info_t info,
	output logic [3:0] month_out,
	output logic [4:0] day_out,
	output logic       error
);

	logic [8:0] t;
	logic [8:0] doy;
	logic [8:0] last;
	logic [3:0] m;
	logic [8:0] dom;

	always_comb begin
		t    = 9'(week_in) * 9'd7 + 9'(weekday_in) + 9'd1;
		doy  = t - 9'(info.jan1);
		last = YEAR_DAYS + 9'(info.leap);
		error = (week_in > MAX_WEEK) || (weekday_in > MAX_WEEKDAY)
			|| (t <= 9'(info.jan1)) || (doy > last);
		if (info.leap && doy > LEAP_DAY_DOY)
			doy = doy - 9'd1;
		// month index = number of month starts that lie before doy
		m = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (days_before(4'(i)) < doy)
				m = m + 4'd1;
		end
		dom = doy - days_before(m);
		if (info.leap && t - 9'(info.jan1) == LEAP_DAY_DOY) begin
			month_out = FEBRUARY;
			day_out   = LEAP_DAY_DOM;
		end else begin
			month_out = m + 4'd1;
			day_out   = dom[4:0];
		end
	end

endmodule

/* design/calendar_week_date_converter_top.sv */
// channel   | handshake              | word
// ----------+------------------------+-----------------------------------------------
// input     | in_valid / in_stall    | command, month, day_of_month, week_in, weekday_in
// result    | out_valid / out_stall  | week_number, weekday, day_of_year, month_out,
//           |                        | day_out, error
// config    | cfg_valid / cfg_ready  | calendar_year
//
// one word per cycle sustained while out_stall is low; each word passes the input register, then the result register
// the conversion is a single pass of table lookup and divide by seven between them
// arst_n clears both valid flags and sets the year to 2018
// out_stall holds the result register; the input register keeps filling until both
// stages are full, then in_stall rises
// cfg_ready is always high; the year's derived facts are latched with the write
module calendar_week_date_converter_top
	import cwdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] calendar_year,

	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [3:0]  month,
	input  logic [5:0]  day_of_month,
	input  logic [5:0]  week_in,
	input  logic [2:0]  weekday_in,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  week_number,
	output logic [2:0]  weekday,
	output logic [8:0]  day_of_year,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic        error
);

	year_info_t info;

	// input register
	logic       valid_s1;
	cmd_t       command_s1;
	logic [3:0] month_s1;
	logic [5:0] day_of_month_s1;
	logic [5:0] week_in_s1;
	logic [2:0] weekday_in_s1;

	// result register
	logic       valid_s2;
	logic [5:0] week_number_s2;
	logic [2:0] weekday_s2;
	logic [8:0] day_of_year_s2;
	logic [3:0] month_out_s2;
	logic [4:0] day_out_s2;
	logic       error_s2;

	// converter outputs
	logic [5:0] fwd_week;
	logic [2:0] fwd_weekday;
	logic [8:0] fwd_doy;
	logic       fwd_err;
	logic [3:0] inv_month;
	logic [4:0] inv_day;
	logic       inv_err;

	// next result word
	logic [5:0] week_number_d;
	logic [2:0] weekday_d;
	logic [8:0] day_of_year_d;
	logic [3:0] month_out_d;
	logic [4:0] day_out_d;
	logic       error_d;

	logic out_free;
	logic load_s1;

	cwdc_year u_year (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.calendar_year (calendar_year),
		.info          (info)
	);

	cwdc_fwd u_fwd (
		.month        (month_s1),
		.day_of_month (day_of_month_s1),
		.info         (info),
		.week_number  (fwd_week),
		.weekday      (fwd_weekday),
		.day_of_year  (fwd_doy),
		.error        (fwd_err)
	);

	cwdc_inv u_inv (
		.week_in    (week_in_s1),
		.weekday_in (weekday_in_s1),
		.info       (info),
		.month_out  (inv_month),
		.day_out    (inv_day),
		.error      (inv_err)
	);

	// result register empties or drains this cycle
	assign out_free = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign load_s1  = in_valid && !in_stall;

	// pick the active direction; any error zeroes the other fields
	always_comb begin
		week_number_d = 6'd0;
		weekday_d     = 3'd0;
		day_of_year_d = 9'd0;
		month_out_d   = 4'd0;
		day_out_d     = 5'd0;
		error_d       = 1'b0;
		if (info.bad) begin
			error_d = 1'b1;
		end else begin
			case (command_s1)
				CMD_DATE_TO_WEEK: begin
					if (fwd_err) begin
						error_d = 1'b1;
					end else begin
						week_number_d = fwd_week;
						weekday_d     = fwd_weekday;
						day_of_year_d = fwd_doy;
					end
				end
				CMD_WEEK_TO_DATE: begin
					if (inv_err) begin
						error_d = 1'b1;
					end else begin
						month_out_d = inv_month;
						day_out_d   = inv_day;
					end
				end
				default: error_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || out_free)
				valid_s1 <= in_valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1      <= cmd_t'(command);
			month_s1        <= month;
			day_of_month_s1 <= day_of_month;
			week_in_s1      <= week_in;
			weekday_in_s1   <= weekday_in;
		end
		if (valid_s1 && out_free) begin
			week_number_s2 <= week_number_d;
			weekday_s2     <= weekday_d;
			day_of_year_s2 <= day_of_year_d;
			month_out_s2   <= month_out_d;
			day_out_s2     <= day_out_d;
			error_s2       <= error_d;
		end
	end

	assign out_valid   = valid_s2;
	assign week_number = week_number_s2;
	assign weekday     = weekday_s2;
	assign day_of_year = day_of_year_s2;
	assign month_out   = month_out_s2;
	assign day_out     = day_out_s2;
	assign error       = error_s2;

endmodule

/* bench/tb_calendar_week_date_converter_top.sv */
module tb_calendar_week_date_converter_top
	import cwdc_pkg::*;
;

	// one request word as it crosses the input channel, in port order
	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] month;
		logic [5:0] dom;
		logic [5:0] week;
		logic [2:0] wday;
	} conv_request_t;

	// one result word, in port order
	typedef struct packed {
		logic [5:0] week_number;
		logic [2:0] weekday;
		logic [8:0] day_of_year;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic       error;
	} conv_result_t;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          RANDOM_WORDS = 84;     // per year phase, nine phases

	// tracks the year in use and the results still owed by the block
	class calendar_scoreboard;
		logic [11:0]  year;
		conv_result_t pending_dates[$];
		int           errors;
		int unsigned  month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
			304, 334};

		function new();
			year   = YEAR_RESET;
			errors = 0;
		endfunction

		function conv_result_t convert_date(conv_request_t r);
			conv_result_t x;
			int unsigned  span, leaps, jan1, doy, t, m, year_len;
			bit           leap;
			x = '0;
			if (year < YEAR_BASE) begin
				x.error = 1'b1;
				return x;
			end
			leap     = (year[1:0] == 2'd0);
			year_len = leap ? 366 : 365;
			span     = year - YEAR_BASE;
			leaps    = (span + 2) / 4;
			if (leap)
				leaps--;
			jan1 = (span + leaps) % 7;
			if (r.cmd == CMD_DATE_TO_WEEK) begin
				if (r.month == 0 || r.month > 12 || r.dom > MAX_DAY) begin
					x.error = 1'b1;
					return x;
				end
				doy = month_start[r.month - 1] + r.dom;
				if (leap && r.month > FEBRUARY)
					doy++;
				t = doy + jan1;
				// day zero of a year starting on monday lands before week 0
				if (t == 0) begin
					x.week_number = '0;
					x.weekday     = SUNDAY;
				end else begin
					x.week_number = 6'((t - 1) / 7);
					x.weekday     = 3'((t - 1) % 7);
				end
				x.day_of_year = 9'(doy);
			end else begin
				if (r.week > MAX_WEEK || r.wday > MAX_WEEKDAY) begin
					x.error = 1'b1;
					return x;
				end
				t = int'(r.week) * 7 + r.wday + 1;
				if (t <= jan1 || t - jan1 > year_len) begin
					x.error = 1'b1;
					return x;
				end
				doy = t - jan1;
				if (leap && doy == LEAP_DAY_DOY) begin
					x.month_out = FEBRUARY;
					x.day_out   = LEAP_DAY_DOM;
					return x;
				end
				if (leap && doy > LEAP_DAY_DOY)
					doy--;
				m = 11;
				while (m > 0 && month_start[m] >= doy)
					m--;
				x.month_out = 4'(m + 1);
				x.day_out   = 5'(doy - month_start[m]);
			end
			return x;
		endfunction

		function void note_request(conv_request_t r);
			pending_dates.push_back(convert_date(r));
		endfunction

		function void compare_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(conv_result_t a);
			conv_result_t e;
			if (pending_dates.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %p", $time, a);
				errors++;
				return;
			end
			e = pending_dates.pop_front();
			compare_field("week_number", e.week_number, a.week_number);
			compare_field("weekday", e.weekday, a.weekday);
			compare_field("day_of_year", e.day_of_year, a.day_of_year);
			compare_field("month_out", e.month_out, a.month_out);
			compare_field("day_out", e.day_out, a.day_out);
			compare_field("error", e.error, a.error);
		endfunction
	endclass

	// clock, reset and every block input start at a known value
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [11:0] calendar_year = YEAR_RESET;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic        command       = 1'b0;
	logic [3:0]  month         = '0;
	logic [5:0]  day_of_month  = '0;
	logic [5:0]  week_in       = '0;
	logic [2:0]  weekday_in    = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [5:0]  week_number;
	logic [2:0]  weekday;
	logic [8:0]  day_of_year;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic        error;

	// idle odds in percent per cycle, switched between phases
	int in_idle_pct = 10;
	int stall_pct   = 62;

	int unsigned        cycle_count = 0;
	calendar_scoreboard sb          = new();

	calendar_week_date_converter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.calendar_year (calendar_year),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.month         (month),
		.day_of_month  (day_of_month),
		.week_in       (week_in),
		.weekday_in    (weekday_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.week_number   (week_number),
		.weekday       (weekday),
		.day_of_year   (day_of_year),
		.month_out     (month_out),
		.day_out       (day_out),
		.error         (error)
	);

	always #2 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99, 0) < stall_pct);
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// monitor: sample handshakes at the edge, before any of this edge's updates land
	always @(posedge clk) begin : monitor
		conv_request_t req;
		conv_result_t  res;
		if (arst_n) begin
			// a year write takes effect for every word accepted after it
			if (cfg_valid && cfg_ready)
				sb.year = calendar_year;
			if (in_valid && !in_stall) begin
				req = {command, month, day_of_month, week_in, weekday_in};
				sb.note_request(req);
			end
			if (out_valid && !out_stall) begin
				res = {week_number, weekday, day_of_year, month_out, day_out, error};
				sb.check_result(res);
			end
		end
	end

	function automatic conv_request_t make_request(cmd_t c, int mon, int dom, int wk, int wd);
		conv_request_t r;
		r.cmd   = c;
		r.month = 4'(mon);
		r.dom   = 6'(dom);
		r.week  = 6'(wk);
		r.wday  = 3'(wd);
		return r;
	endfunction

	// mostly legal requests, with a share of out-of-range fields; the fields the
	// command ignores are random too
	function automatic conv_request_t random_request();
		conv_request_t r;
		int            pick;
		r.cmd = cmd_t'($urandom_range(1, 0));
		if ($urandom_range(9, 0) == 0) begin
			pick    = $urandom_range(3, 0);
			r.month = (pick == 0) ? 4'd0 : 4'(12 + pick);
		end else begin
			r.month = 4'($urandom_range(12, 1));
		end
		r.dom  = ($urandom_range(7, 0) == 0) ? 6'($urandom_range(63, 32))
			: 6'($urandom_range(31, 0));
		r.week = ($urandom_range(7, 0) == 0) ? 6'($urandom_range(63, 54))
			: 6'($urandom_range(53, 0));
		r.wday = ($urandom_range(9, 0) == 0) ? 3'd7 : 3'($urandom_range(6, 0));
		return r;
	endfunction

	// present one word after a random idle stretch, hold it until it is taken
	task automatic send_request(conv_request_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99, 0) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= r.cmd;
		month        <= r.month;
		day_of_month <= r.dom;
		week_in      <= r.week;
		weekday_in   <= r.wday;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// every word yields a result, so an empty queue means the block is idle;
	// valid drops first so the last word is not taken again, and the first edge
	// lets the monitor note a word taken at the calling edge
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_dates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_year(logic [11:0] y);
		in_valid      <= 1'b0;
		cfg_valid     <= 1'b1;
		calendar_year <= y;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [11:0] year_list[9];
		year_list = '{12'd2020, 12'd4095, 12'd0, 12'd2017, 12'd2099, 12'd2019, 12'd2047,
			12'd0, 12'd0};
		year_list[7] = 12'($urandom_range(2099, 2018));
		year_list[8] = 12'($urandom_range(4095, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset year 2018 starts on a monday, not leap
		send_request(make_request(CMD_DATE_TO_WEEK, 1, 0, 0, 0));    // day zero, before week 0
		send_request(make_request(CMD_DATE_TO_WEEK, 1, 1, 0, 0));
		send_request(make_request(CMD_DATE_TO_WEEK, 12, 31, 0, 0));
		send_request(make_request(CMD_DATE_TO_WEEK, 2, 31, 0, 0));   // impossible date, no error
		send_request(make_request(CMD_DATE_TO_WEEK, 0, 5, 0, 0));    // month zero
		send_request(make_request(CMD_DATE_TO_WEEK, 13, 1, 0, 0));
		send_request(make_request(CMD_DATE_TO_WEEK, 15, 63, 63, 7));
		send_request(make_request(CMD_DATE_TO_WEEK, 12, 32, 0, 0));  // day just past 31
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 0, 0));    // january 1
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 52, 0));   // december 31
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 8, 3));    // march 1, no leap day
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 53, 6));   // past year end
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 54, 0));   // week out of range
		send_request(make_request(CMD_WEEK_TO_DATE, 15, 63, 63, 7));
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 1, 7));    // weekday 7

		// leap year that also starts on a monday
		wait_drained();
		write_year(12'd2024);
		send_request(make_request(CMD_DATE_TO_WEEK, 2, 29, 0, 0));
		send_request(make_request(CMD_DATE_TO_WEEK, 3, 1, 0, 0));
		send_request(make_request(CMD_DATE_TO_WEEK, 12, 31, 0, 0));
		send_request(make_request(CMD_DATE_TO_WEEK, 1, 0, 0, 0));
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 8, 3));    // leap day itself
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 8, 4));    // day after leap day
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 52, 1));   // day 366
		send_request(make_request(CMD_WEEK_TO_DATE, 0, 0, 52, 2));   // one past the year

		// random phases, one year each; years below 2018 flag every word
		for (int ph = 0; ph < 9; ph++) begin
			wait_drained();
			write_year(year_list[ph]);
			case (ph / 3)
				0: begin
					in_idle_pct <= 10;
					stall_pct   <= 62;
				end
				1: begin
					in_idle_pct <= 62;
					stall_pct   <= 10;
				end
				default: begin
					in_idle_pct <= 0;
					stall_pct   <= 0;
				end
			endcase
			repeat (RANDOM_WORDS)
				send_request(random_request());
		end

		in_valid <= 1'b0;
		wait_drained();
		// a few more edges to catch any stray result word
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
